### hdl/cwsam_pkg.sv
// Shared constants, state encoding and control structs for the schedule clock.
`timescale 1ns / 1ps

package cwsam_pkg;

    localparam int C_MAX_SLOTS     = 9;
    localparam int C_SECS_PER_MIN  = 60;
    localparam int C_MINS_PER_HOUR = 60;
    localparam int C_HOURS_PER_DAY = 24;

    localparam int C_SEC_W   = 6;
    localparam int C_MIN_W   = 6;
    localparam int C_HOUR_W  = 5;
    localparam int C_UNITS_W = 8;
    localparam int C_IDX_W   = 4;
    localparam int C_SLOT_W  = 4;
    localparam int C_CFG_W   = 4;

    // Input item kind carried in tuser.
    localparam logic C_OP_TICK  = 1'b0;
    localparam logic C_OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic tick;      // accept a one-second tick
        logic write;     // accept a slot write
        logic scan_run;  // step the schedule scan
    } t_cmd;

    typedef struct packed {
        logic tick_rolls;  // the current time is at the last second of a minute
        logic scan_done;   // the scan has found a match or run out of slots
    } t_status;

endpackage

### hdl/cwsam_ctrl.sv
// Control state machine that sequences tick, write, schedule scan and result transfer.
`timescale 1ns / 1ps

module cwsam_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_op,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output cwsam_pkg::t_cmd     o_cmd,
    input  cwsam_pkg::t_status  i_status
);

    cwsam_pkg::t_state r_state;
    cwsam_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwsam_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cwsam_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_op == cwsam_pkg::C_OP_TICK && i_status.tick_rolls) begin
                        n_state = cwsam_pkg::ST_SCAN;
                    end else begin
                        n_state = cwsam_pkg::ST_OUT;
                    end
                end
            end
            cwsam_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = cwsam_pkg::ST_OUT;
                end
            end
            cwsam_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = cwsam_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cwsam_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_m_tvalid     = 1'b0;
        o_cmd.tick     = 1'b0;
        o_cmd.write    = 1'b0;
        o_cmd.scan_run = 1'b0;
        case (r_state)
            cwsam_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.tick  = i_s_tvalid && (i_op == cwsam_pkg::C_OP_TICK);
                o_cmd.write = i_s_tvalid && (i_op == cwsam_pkg::C_OP_WRITE);
            end
            cwsam_pkg::ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
            end
            cwsam_pkg::ST_OUT: begin
                o_m_tvalid = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/cwsam_dpath.sv
// Datapath: time counters, schedule memory with valid bits, scan counter and result registers.
`timescale 1ns / 1ps

module cwsam_dpath #(
    parameter int MAX_SLOTS = cwsam_pkg::C_MAX_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cwsam_pkg::t_cmd                   i_cmd,
    output cwsam_pkg::t_status                o_status,
    input  logic                              i_cfg_we,
    input  logic [cwsam_pkg::C_CFG_W-1:0]     i_cfg_wdata,
    input  logic [cwsam_pkg::C_IDX_W-1:0]     i_slot_index,
    input  logic [cwsam_pkg::C_HOUR_W-1:0]    i_slot_hour,
    input  logic [cwsam_pkg::C_MIN_W-1:0]     i_slot_minute,
    input  logic [cwsam_pkg::C_UNITS_W-1:0]   i_slot_units,
    output logic [cwsam_pkg::C_SEC_W-1:0]     o_seconds_now,
    output logic [cwsam_pkg::C_MIN_W-1:0]     o_minutes_now,
    output logic [cwsam_pkg::C_HOUR_W-1:0]    o_hours_now,
    output logic                              o_minute_rollover,
    output logic [cwsam_pkg::C_SLOT_W-1:0]    o_match_slot,
    output logic [cwsam_pkg::C_UNITS_W-1:0]   o_match_units
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int UW = cwsam_pkg::C_UNITS_W;
    localparam int MW = cwsam_pkg::C_MIN_W;
    localparam int HW = cwsam_pkg::C_HOUR_W;
    localparam int EW = HW + MW + UW;

    // Time counters.
    logic [cwsam_pkg::C_SEC_W-1:0]  r_sec;
    logic [MW-1:0]                  r_min;
    logic [HW-1:0]                  r_hr;
    logic                           sec_last;
    logic                           min_last;
    logic                           hr_last;

    assign sec_last = (r_sec == cwsam_pkg::C_SEC_W'(cwsam_pkg::C_SECS_PER_MIN - 1));
    assign min_last = (r_min == MW'(cwsam_pkg::C_MINS_PER_HOUR - 1));
    assign hr_last  = (r_hr == HW'(cwsam_pkg::C_HOURS_PER_DAY - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= '0;
            r_min <= '0;
            r_hr  <= '0;
        end else if (i_cmd.tick) begin
            if (sec_last) begin
                r_sec <= '0;
                if (min_last) begin
                    r_min <= '0;
                    r_hr  <= hr_last ? '0 : r_hr + HW'(1);
                end else begin
                    r_min <= r_min + MW'(1);
                end
            end else begin
                r_sec <= r_sec + cwsam_pkg::C_SEC_W'(1);
            end
        end
    end

    // Active slot count register.
    logic [cwsam_pkg::C_CFG_W-1:0] r_active;
    logic [CW-1:0]                 limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign limit = (32'(r_active) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(r_active);

    // Schedule memory; an entry never written reads as all zero through its valid bit.
    logic [EW-1:0]        mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_valid;
    logic [EW-1:0]        r_rd_data;
    logic                 r_rd_ok;
    logic                 wr_ok;
    logic [AW-1:0]        wr_addr;
    logic [CW-1:0]        r_rd_idx;
    logic                 rd_en;

    assign wr_ok   = i_cmd.write && (32'(i_slot_index) < MAX_SLOTS);
    assign wr_addr = AW'(i_slot_index);
    assign rd_en   = i_cmd.scan_run && (r_rd_idx < limit);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= {i_slot_hour, i_slot_minute, i_slot_units};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[AW-1:0]];
            r_rd_ok   <= r_valid[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_ok) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Scan: one read issued per cycle, compared in the cycle after it is issued.
    logic [AW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic          r_found;
    logic          hit;
    logic [HW-1:0] ent_hour;
    logic [MW-1:0] ent_min;
    logic [UW-1:0] ent_units;

    assign ent_hour  = r_rd_ok ? r_rd_data[EW-1 -: HW] : '0;
    assign ent_min   = r_rd_ok ? r_rd_data[UW +: MW] : '0;
    assign ent_units = r_rd_ok ? r_rd_data[UW-1:0] : '0;
    assign hit       = r_cmp_vld && !r_found && (ent_hour == r_hr) && (ent_min == r_min);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
        end
    end

    logic                          r_roll;
    logic [cwsam_pkg::C_SLOT_W-1:0] r_mslot;
    logic [UW-1:0]                 r_munits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_roll    <= 1'b0;
            r_mslot   <= '0;
            r_munits  <= '0;
        end else if (i_cmd.tick || i_cmd.write) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_roll    <= i_cmd.tick && sec_last;
            r_mslot   <= '0;
            r_munits  <= '0;
        end else if (i_cmd.scan_run) begin
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            r_cmp_vld <= rd_en;
            if (hit) begin
                r_found  <= 1'b1;
                r_mslot  <= cwsam_pkg::C_SLOT_W'(32'(r_cmp_idx) + 1);
                r_munits <= ent_units;
            end
        end
    end

    assign o_status.tick_rolls = sec_last;
    assign o_status.scan_done  = r_found || (!r_cmp_vld && (r_rd_idx >= limit));

    assign o_seconds_now     = r_sec;
    assign o_minutes_now     = r_min;
    assign o_hours_now       = r_hr;
    assign o_minute_rollover = r_roll;
    assign o_match_slot      = r_mslot;
    assign o_match_units     = r_munits;

endmodule

### hdl/clock_with_schedule_alarm_match_top.sv
// Top level of the real-time clock with schedule table matching.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// s         in   i_s_tvalid / o_s_tready    i_s_tdata (slot write fields), i_s_tuser (op)
// m         out  o_m_tvalid / i_m_tready    o_m_tdata (time, rollover, match)
// cfg       in   i_cfg_we                   i_cfg_wdata (active_entries)
//
// A write, or a tick that does not complete a minute, can make its result transfer in the cycle
// after the input transfer. A tick that completes a minute first scans L = min(active_entries,
// MAX_SLOTS) slots, one read per cycle with each read compared in the cycle after it, and
// stops at the first matching slot or after the last, before its result can transfer.
// Reset is synchronous and active low; per-slot valid bits make the table read as cleared.
// One item is in flight: input stalls until the result transfer, which holds while stalled.

module clock_with_schedule_alarm_match_top #(
    parameter int MAX_SLOTS = cwsam_pkg::C_MAX_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] slot_index, [8:4] slot_hour, [14:9] slot_minute, [22:15] slot_units, [23] zero
    input  logic [23:0] i_s_tdata,
    // [0] op
    input  logic [0:0]  i_s_tuser,
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] seconds_now, [11:6] minutes_now, [16:12] hours_now, [17] minute_rollover,
    // [21:18] match_slot, [29:22] match_units, [31:30] zero
    output logic [31:0] o_m_tdata,
    // Configuration write of active_entries.
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);

    cwsam_pkg::t_cmd    cmd;
    cwsam_pkg::t_status status;

    logic [cwsam_pkg::C_SEC_W-1:0]   seconds_now;
    logic [cwsam_pkg::C_MIN_W-1:0]   minutes_now;
    logic [cwsam_pkg::C_HOUR_W-1:0]  hours_now;
    logic                            minute_rollover;
    logic [cwsam_pkg::C_SLOT_W-1:0]  match_slot;
    logic [cwsam_pkg::C_UNITS_W-1:0] match_units;

    // The controller decides when a transfer is taken and when the scan runs.
    cwsam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // The datapath keeps the time, the table and the result registers; the result fields
    // stay put between transfers because they change only on a new input transfer or scan.
    cwsam_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_slot_index      (i_s_tdata[3:0]),
        .i_slot_hour       (i_s_tdata[8:4]),
        .i_slot_minute     (i_s_tdata[14:9]),
        .i_slot_units      (i_s_tdata[22:15]),
        .o_seconds_now     (seconds_now),
        .o_minutes_now     (minutes_now),
        .o_hours_now       (hours_now),
        .o_minute_rollover (minute_rollover),
        .o_match_slot      (match_slot),
        .o_match_units     (match_units)
    );

    assign o_m_tdata = {2'b00, match_units, match_slot, minute_rollover,
                        hours_now, minutes_now, seconds_now};

`ifndef SYNTHESIS
    // Only one item is in flight, so input and output are never open together.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");

    // A reported match can only come from a tick that completed a minute.
    a_match_needs_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[21:18] != 4'd0)) |-> o_m_tdata[17])
        else $error("match reported without minute rollover");

    // A slot write leaves the time untouched.
    a_write_keeps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0]) |=> $stable(o_m_tdata[16:0]))
        else $error("slot write moved the clock");

    // A write result never carries rollover or match information.
    a_write_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0]) |=> (o_m_tdata[29:17] == 13'd0))
        else $error("slot write produced rollover or match fields");
`endif

endmodule
